[sv/rc4_pkg.sv]
// Shared types and constants for the RC4 stream decrypt unit.
`timescale 1ns / 1ps

package rc4_pkg;

  // Permutation table geometry: one byte per entry, indexed by a byte.
  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;
  localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_DEPTH - 1);

  // Key store geometry.
  localparam int KEY_DEPTH = 256;
  localparam int KEY_AW    = 8;

  // Key length register.
  localparam int KEY_LEN_W = 9;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = KEY_LEN_W'(KEY_DEPTH);

  // Commands carried by an input item.
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  // Register word index in the configuration space.
  localparam logic REG_KEY_LENGTH = 1'b0;

  // One input item as decoded from the slave stream.
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] key_index;
    logic       first_of_message;
    logic       command;
  } rc4_item_t;

endpackage

[sv/rc4_stream_decrypt_unit.sv]
// Top level of the RC4 stream decrypt unit.
//
//   Channel  Dir  Handshake                    Payload
//   s_*      in   s_tvalid / s_tready          s_tdata, s_tuser
//   m_*      out  m_tvalid / m_tready          m_tdata
//   apb      in   psel & penable & pwrite      paddr, pwdata, prdata (pready tied high)
//
// A key byte is written to the key store in the cycle it is accepted; the unit is
// ready again in the next cycle. A data byte steps through the sequencer states PR_RD,
// PR_J, PR_W1, PR_W2, PR_KS, PR_XR and PR_OUT, as the permutation memory, with one read
// port and one write port, serves its three reads and two writes. A first-of-message
// data byte first fills the permutation, then runs the key schedule (KS_RD, KS_J,
// KS_W1 and KS_W2 per swap). The result waits in an output register; a stalled
// m_tready holds the unit only when a second result is ready. Reset clears the
// sequencer and indices and sets the key length to 16.
`timescale 1ns / 1ps

module rc4_stream_decrypt_unit
  import rc4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] key_index, [15:8] value
  input  logic [1:0]  s_tuser,   // [0] command, [1] first_of_message
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] data_out
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [KEY_LEN_W-1:0] key_length;
  rc4_item_t            item;

  // Unpack one input transfer.
  assign item.command          = s_tuser[0];
  assign item.first_of_message = s_tuser[1];
  assign item.key_index        = s_tdata[7:0];
  assign item.value            = s_tdata[15:8];

  rc4_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .key_length (key_length)
  );

  rc4_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .key_length (key_length),
    .item_valid (s_tvalid),
    .item_ready (s_tready),
    .item       (item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

endmodule

[sv/rc4_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rc4_regs.sv]
// APB-style configuration register block holding the key length.
`timescale 1ns / 1ps

module rc4_regs
  import rc4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output logic [KEY_LEN_W-1:0] key_length
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // The register is written in the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LEN_RESET;
    end else if (wr_en && (paddr[2] == REG_KEY_LENGTH)) begin
      key_length <= pwdata[KEY_LEN_W-1:0];
    end
  end

  // Read-back; only paddr[2] is decoded, so addresses with paddr[2] set read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_KEY_LENGTH) begin
      prdata = {{(32-KEY_LEN_W){1'b0}}, key_length};
    end
  end

endmodule

[sv/rc4_engine.sv]
// RC4 sequencer: key store, permutation memory, shared byte adder and output register.
`timescale 1ns / 1ps

module rc4_engine
  import rc4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [KEY_LEN_W-1:0] key_length,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rc4_item_t            item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_data
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FILL  = 4'd1;
  localparam logic [3:0] ST_KS_RD = 4'd2;
  localparam logic [3:0] ST_KS_J  = 4'd3;
  localparam logic [3:0] ST_KS_W1 = 4'd4;
  localparam logic [3:0] ST_KS_W2 = 4'd5;
  localparam logic [3:0] ST_PR_RD = 4'd6;
  localparam logic [3:0] ST_PR_J  = 4'd7;
  localparam logic [3:0] ST_PR_W1 = 4'd8;
  localparam logic [3:0] ST_PR_W2 = 4'd9;
  localparam logic [3:0] ST_PR_KS = 4'd10;
  localparam logic [3:0] ST_PR_XR = 4'd11;
  localparam logic [3:0] ST_PR_OUT = 4'd12;

  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [PERM_AW-1:0] idx_i;
  logic [PERM_AW-1:0] idx_j;
  logic [PERM_AW-1:0] step;
  logic [KEY_AW-1:0]  key_pos;
  logic [7:0]         held_a;
  logic [7:0]         held_b;
  logic [7:0]         data_byte;

  // Memory ports.
  logic               perm_we;
  logic [PERM_AW-1:0] perm_waddr;
  logic [7:0]         perm_wdata;
  logic [PERM_AW-1:0] perm_raddr;
  logic [7:0]         perm_rdata;
  logic               key_we;
  logic [7:0]         key_rdata;

  // Shared three-input byte adder.
  logic [7:0] add_a;
  logic [7:0] add_b;
  logic [7:0] add_c;
  logic [7:0] add_sum;

  // Key position bookkeeping.
  logic [KEY_LEN_W-1:0] eff_len;
  logic [KEY_AW:0]      key_pos_inc;
  logic [KEY_AW-1:0]    key_pos_next;

  logic accept;
  logic out_free;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid & item_ready;
  assign out_free   = ~out_valid | out_ready;

  assign key_we = accept && (item.command == CMD_KEY) &&
                  ({1'b0, item.key_index} < KEY_LEN_MAX);

  rc4_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (item.key_index[KEY_AW-1:0]),
    .wdata (item.value),
    .raddr (key_pos),
    .rdata (key_rdata)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm_ram (
    .clk   (clk),
    .we    (perm_we),
    .waddr (perm_waddr),
    .wdata (perm_wdata),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  // A zero key length counts as one; anything above the store depth saturates.
  always_comb begin
    if (key_length == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_length > KEY_LEN_MAX) begin
      eff_len = KEY_LEN_MAX;
    end else begin
      eff_len = key_length;
    end
    key_pos_inc = {1'b0, key_pos} + (KEY_AW+1)'(1);
    if (KEY_LEN_W'(key_pos_inc) >= eff_len) begin
      key_pos_next = '0;
    end else begin
      key_pos_next = key_pos_inc[KEY_AW-1:0];
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    add_a = step;
    add_b = 8'd1;
    add_c = 8'd0;
    case (state)
      ST_KS_J: begin
        add_a = idx_j;
        add_b = perm_rdata;
        add_c = key_rdata;
      end
      ST_PR_RD: begin
        add_a = idx_i;
      end
      ST_PR_J: begin
        add_a = idx_j;
        add_b = perm_rdata;
      end
      ST_PR_KS: begin
        add_a = held_a;
        add_b = held_b;
      end
      default: begin
        add_a = step;
      end
    endcase
  end

  assign add_sum = add_a + add_b + add_c;

  // Permutation memory addressing and writes.
  always_comb begin
    perm_we    = 1'b0;
    perm_waddr = step;
    perm_wdata = step;
    perm_raddr = step;
    case (state)
      ST_FILL: begin
        perm_we = 1'b1;
      end
      ST_KS_J: begin
        perm_raddr = add_sum;
      end
      ST_KS_W1: begin
        perm_we    = 1'b1;
        perm_wdata = perm_rdata;
      end
      ST_KS_W2: begin
        perm_we    = 1'b1;
        perm_waddr = idx_j;
        perm_wdata = held_a;
      end
      ST_PR_RD: begin
        perm_raddr = add_sum;
      end
      ST_PR_J: begin
        perm_raddr = add_sum;
      end
      ST_PR_W1: begin
        perm_we    = 1'b1;
        perm_waddr = idx_i;
        perm_wdata = perm_rdata;
      end
      ST_PR_W2: begin
        perm_we    = 1'b1;
        perm_waddr = idx_j;
        perm_wdata = held_a;
      end
      ST_PR_KS: begin
        perm_raddr = add_sum;
      end
      default: begin
        perm_we = 1'b0;
      end
    endcase
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (item.command == CMD_DATA)) begin
          state_next = item.first_of_message ? ST_FILL : ST_PR_RD;
        end
      end
      ST_FILL:   state_next = (step == PERM_LAST) ? ST_KS_RD : ST_FILL;
      ST_KS_RD:  state_next = ST_KS_J;
      ST_KS_J:   state_next = ST_KS_W1;
      ST_KS_W1:  state_next = ST_KS_W2;
      ST_KS_W2:  state_next = (step == PERM_LAST) ? ST_PR_RD : ST_KS_RD;
      ST_PR_RD:  state_next = ST_PR_J;
      ST_PR_J:   state_next = ST_PR_W1;
      ST_PR_W1:  state_next = ST_PR_W2;
      ST_PR_W2:  state_next = ST_PR_KS;
      ST_PR_KS:  state_next = ST_PR_XR;
      ST_PR_XR:  state_next = ST_PR_OUT;
      ST_PR_OUT: state_next = out_free ? ST_IDLE : ST_PR_OUT;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control state: sequencer, stream indices, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx_i     <= '0;
      idx_j     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_FILL: begin
          idx_j <= '0;
        end
        ST_KS_J: begin
          idx_j <= add_sum;
        end
        ST_KS_W2: begin
          // The key schedule ends with both stream indices cleared.
          if (step == PERM_LAST) begin
            idx_i <= '0;
            idx_j <= '0;
          end
        end
        ST_PR_RD: begin
          idx_i <= add_sum;
        end
        ST_PR_J: begin
          idx_j <= add_sum;
        end
        default: begin
          idx_i <= idx_i;
        end
      endcase
      if (state == ST_PR_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers: step counter, key position, held bytes and the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      data_byte <= item.value;
      step      <= '0;
      key_pos   <= '0;
    end
    case (state)
      ST_FILL: begin
        step    <= add_sum;
        key_pos <= '0;
      end
      ST_KS_J: begin
        held_a <= perm_rdata;
      end
      ST_KS_W2: begin
        step    <= add_sum;
        key_pos <= key_pos_next;
      end
      ST_PR_J: begin
        held_a <= perm_rdata;
      end
      ST_PR_W1: begin
        held_b <= perm_rdata;
      end
      ST_PR_XR: begin
        data_byte <= data_byte ^ perm_rdata;
      end
      ST_PR_OUT: begin
        if (out_free) begin
          out_data <= data_byte;
        end
      end
      default: begin
        held_b <= held_b;
      end
    endcase
  end

endmodule

[sv/rc4_checker.sv]
// Port-level checker for the RC4 stream decrypt unit, bound to the top level.
`timescale 1ns / 1ps

module rc4_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // No result is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // A data transfer occupies the sequencer for the following cycle.
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
    else $error("accepted a transfer while busy with a data byte");

  // A key byte is written and leaves the unit ready in the next cycle.
  a_key_ready: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser[0]) |=> s_tready)
    else $error("unit not ready after a key byte");

endmodule

bind rc4_stream_decrypt_unit rc4_checker u_checker (.*);
